// ===== rtl/lbbrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lbbrt_pkg;
    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_WRITE = 2'd3
    } t_req;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam int unsigned RB_W = 38;

    // broadcast command from the controller to every cell
    typedef struct packed {
        logic        match_en;   // compare enable; unused, cells always compare
        logic [31:0] handle;
        logic        alloc_en;   // claim entry at alloc_idx
        logic        sel_en;     // operate on the selected entry
        logic [31:0] new_size;
        logic        rank_ins;   // insert selected at mru
        logic        rank_prom;  // promote selected
        logic        rank_drop;  // drop selected (evict or free)
        logic        set_dirty;
        logic        kill;       // free: clear valid
    } t_cmd;
endpackage
`default_nettype wire

// ===== rtl/lru_byte_budget_residency_tracker_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// LRU residency tracker: a row of MAX_BLOCKS cells, each holding one block's
// handle, size, resident and dirty marks and its recency rank. A request is
// taken while idle, the associative lookup (chained first-hit through the
// cells) and free-slot search happen in the next cycle, then a decide step
// either completes a failed request or an access whose offset lies past the
// block end, or picks the path. Each eviction is a find step (the cell whose
// rank equals resident count minus one) and an evict step (drop it and emit
// its report), then an apply step updates the cells and a done step emits
// the completion. Only one request is in flight; results leave through a
// one-deep output register, and the decide, evict and done steps wait while
// that register still holds an untaken result. The budget register may be
// written at any time and is used at the next check.
module lru_byte_budget_residency_tracker_core
    import lbbrt_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [31:0]  i_cfg_data,      // budget_bytes
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [127:0] s_axis_tdata,    // handle, block_size, offset, length
    input  wire  [1:0]   s_axis_tuser,    // req_type
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [143:0] m_axis_tdata,    // evicted_handle, evicted_dirty, status,
                                          // result_handle, byte_count, bytes_in_use
    output logic         m_axis_tuser,    // kind
    output logic         m_axis_tlast     // last
);
    localparam int unsigned N  = MAX_BLOCKS;
    localparam int unsigned RW = (N > 1) ? $clog2(N) : 1;
    localparam int unsigned IW = RW;

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_DECIDE, S_FIND, S_EVICT, S_APPLY, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [31:0] r_budget, n_budget;
    logic [1:0]  r_type, n_type;
    logic [31:0] r_h, r_bsize, r_off, r_len;
    logic [31:0] n_h, n_bsize, n_off, n_len;
    logic [31:0] r_next_h, n_next_h;
    logic [RB_W-1:0] r_rbytes, n_rbytes;
    logic [IW-1:0] r_idx, r_free_idx, n_idx, n_free_idx;
    logic r_found, r_has_free, n_found, n_has_free;
    logic [31:0] r_need, r_cnt, n_need, n_cnt;
    logic [RW:0] r_nres, n_nres;
    // output register
    logic r_ov, n_ov;
    logic [143:0] r_od, n_od;
    logic r_ou, r_ol, n_ou, n_ol;

    t_cmd w_cmd;
    logic [N-1:0] w_valid, w_res, w_dirty, w_hit, w_chain;
    logic [31:0] w_handle [N];
    logic [31:0] w_size [N];
    logic [RW-1:0] w_rank [N];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            lbbrt_cell #(.RANK_W(RW)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
                .i_alloc_me(r_free_idx == IW'(g)),
                .i_sel_me(r_idx == IW'(g)),
                .i_sel_rank(w_rank[r_idx]),
                .i_found_prev(g == 0 ? 1'b0 : w_chain[(g == 0) ? 0 : g-1]),
                .o_found_next(w_chain[g]), .o_hit_first(w_hit[g]),
                .o_valid(w_valid[g]), .o_resident(w_res[g]), .o_dirty(w_dirty[g]),
                .o_handle(w_handle[g]), .o_size(w_size[g]), .o_rank(w_rank[g])
            );
        end
    endgenerate

    // hit index, free index and lru index encoders
    logic [IW-1:0] w_hit_idx, w_free_idx, w_lru_idx;
    logic w_any_free, w_any_res;
    always_comb begin
        w_hit_idx = '0;
        w_free_idx = '0;
        w_lru_idx = '0;
        w_any_free = 1'b0;
        w_any_res = 1'b0;
        for (int j = N - 1; j >= 0; j--) begin
            if (w_hit[j]) w_hit_idx = IW'(j);
            if (!w_valid[j]) begin
                w_free_idx = IW'(j);
                w_any_free = 1'b1;
            end
            if (w_res[j] && ({1'b0, w_rank[j]} == r_nres - 1'b1)) begin
                w_lru_idx = IW'(j);
                w_any_res = 1'b1;
            end
        end
    end

    logic [RB_W-1:0] w_free_sp;
    assign w_free_sp = ({6'd0, r_budget} > r_rbytes) ? {6'd0, r_budget} - r_rbytes : '0;

    // resident bytes with the selected block taken out, floored at zero
    logic [RB_W-1:0] w_rb_less;
    assign w_rb_less = (r_rbytes >= {6'd0, w_size[r_idx]})
        ? r_rbytes - {6'd0, w_size[r_idx]} : '0;

    logic w_out_free;
    assign w_out_free = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_cmd = '0;
        w_cmd.handle = (r_type == REQ_ALLOC) ? r_next_h : r_h;
        w_cmd.new_size = r_bsize;
        if (r_state == S_EVICT && w_out_free) begin
            w_cmd.sel_en = 1'b1;
            w_cmd.rank_drop = 1'b1;
        end
        if (r_state == S_APPLY) begin
            w_cmd.sel_en = 1'b1;
            case (r_type)
                REQ_ALLOC: begin
                    w_cmd.alloc_en = 1'b1;
                    w_cmd.rank_ins = 1'b1;
                end
                REQ_FREE: begin
                    w_cmd.kill = 1'b1;
                    w_cmd.rank_drop = w_res[r_idx];
                    w_cmd.sel_en = 1'b1;
                end
                default: begin
                    w_cmd.rank_ins = !w_res[r_idx];
                    w_cmd.rank_prom = w_res[r_idx];
                    w_cmd.set_dirty = (r_type == REQ_WRITE);
                end
            endcase
        end
    end

    logic [31:0] w_room;
    assign w_room = w_size[r_idx] - r_off;

    // result layout: handle 31:0, dirty 32, status 34:33, new handle 66:35,
    // byte count 98:67, bytes in use 136:99
    always_comb begin
        n_state = r_state;
        n_budget = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_budget;
        n_type = r_type;
        n_h = r_h;
        n_bsize = r_bsize;
        n_off = r_off;
        n_len = r_len;
        n_next_h = r_next_h;
        n_rbytes = r_rbytes;
        n_idx = r_idx;
        n_free_idx = r_free_idx;
        n_found = r_found;
        n_has_free = r_has_free;
        n_need = r_need;
        n_cnt = r_cnt;
        n_nres = r_nres;
        n_ov = (r_ov && m_axis_tready) ? 1'b0 : r_ov;
        n_od = r_od;
        n_ou = r_ou;
        n_ol = r_ol;
        case (r_state)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                n_type = s_axis_tuser;
                n_h = s_axis_tdata[31:0];
                n_bsize = s_axis_tdata[63:32];
                n_off = s_axis_tdata[95:64];
                n_len = s_axis_tdata[127:96];
                n_state = S_LOOK;
            end
            S_LOOK: begin
                n_idx = w_hit_idx;
                n_found = |w_hit;
                n_free_idx = w_free_idx;
                n_has_free = w_any_free;
                n_state = S_DECIDE;
            end
            S_DECIDE: if (w_out_free) begin
                // completion fields for a request that ends here
                n_od = '0;
                n_od[136:99] = r_rbytes;
                n_ou = 1'b1;
                n_ol = 1'b1;
                n_state = S_IDLE;
                if (r_type == REQ_ALLOC) begin
                    if (r_bsize == 32'd0) begin
                        n_od[34:33] = ST_INVALID;
                        n_ov = 1'b1;
                    end else if (!r_has_free) begin
                        n_od[34:33] = ST_FULL;
                        n_ov = 1'b1;
                    end else begin
                        n_need = r_bsize;
                        n_idx = r_free_idx;
                        n_state = S_FIND;
                    end
                end else if (r_h == 32'd0) begin
                    n_od[34:33] = ST_INVALID;
                    n_ov = 1'b1;
                end else if (!r_found) begin
                    n_od[34:33] = ST_NOT_FOUND;
                    n_ov = 1'b1;
                end else if (r_type == REQ_FREE) begin
                    n_state = S_APPLY;
                end else if (r_off >= w_size[r_idx]) begin
                    // offset past the end: nothing moves, nothing promoted
                    n_od[34:33] = ST_OK;
                    n_ov = 1'b1;
                end else begin
                    n_cnt = (r_len < w_room) ? r_len : w_room;
                    n_need = w_size[r_idx];
                    n_state = w_res[r_idx] ? S_APPLY : S_FIND;
                end
            end
            S_FIND: begin
                if (w_free_sp < {6'd0, r_need} && w_any_res) begin
                    n_free_idx = r_idx;
                    n_idx = w_lru_idx;
                    n_state = S_EVICT;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_EVICT: if (w_out_free) begin
                n_rbytes = w_rb_less;
                n_od = '0;
                n_od[31:0] = w_handle[r_idx];
                n_od[32] = w_dirty[r_idx];
                n_od[136:99] = w_rb_less;
                n_ou = 1'b0;
                n_ol = 1'b0;
                n_ov = 1'b1;
                n_nres = r_nres - 1'b1;
                n_idx = r_free_idx;
                n_state = S_FIND;
            end
            S_APPLY: begin
                case (r_type)
                    REQ_ALLOC: begin
                        n_rbytes = r_rbytes + {6'd0, r_bsize};
                        n_nres = r_nres + 1'b1;
                    end
                    REQ_FREE: if (w_res[r_idx]) begin
                        n_rbytes = w_rb_less;
                        n_nres = r_nres - 1'b1;
                    end
                    default: if (!w_res[r_idx]) begin
                        n_rbytes = r_rbytes + {6'd0, w_size[r_idx]};
                        n_nres = r_nres + 1'b1;
                    end
                endcase
                n_state = S_DONE;
            end
            S_DONE: if (w_out_free) begin
                n_od = '0;
                n_od[34:33] = ST_OK;
                if (r_type == REQ_ALLOC) begin
                    n_od[66:35] = r_next_h;
                    n_next_h = (r_next_h == 32'hFFFF_FFFF) ? 32'd1 : r_next_h + 1'b1;
                end
                if (r_type == REQ_READ || r_type == REQ_WRITE) n_od[98:67] = r_cnt;
                n_od[136:99] = r_rbytes;
                n_ou = 1'b1;
                n_ol = 1'b1;
                n_ov = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_budget <= 32'd65536;
            r_next_h <= 32'd1;
            r_rbytes <= '0;
            r_nres <= '0;
            r_ov <= 1'b0;
            r_ou <= 1'b0;
            r_ol <= 1'b0;
            r_idx <= '0;
            r_free_idx <= '0;
        end else begin
            r_state <= n_state;
            r_budget <= n_budget;
            r_type <= n_type;
            r_h <= n_h;
            r_bsize <= n_bsize;
            r_off <= n_off;
            r_len <= n_len;
            r_next_h <= n_next_h;
            r_rbytes <= n_rbytes;
            r_idx <= n_idx;
            r_free_idx <= n_free_idx;
            r_found <= n_found;
            r_has_free <= n_has_free;
            r_need <= n_need;
            r_cnt <= n_cnt;
            r_nres <= n_nres;
            r_ov <= n_ov;
            r_od <= n_od;
            r_ou <= n_ou;
            r_ol <= n_ol;
        end
    end

    assign m_axis_tdata  = r_od;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_ou;
    assign m_axis_tlast  = r_ol;

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser)) else $error("last without completion");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
    a_nres: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= (RW+1)'(N)) else $error("resident count overflow");
endmodule
`default_nettype wire

// ===== rtl/lbbrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lbbrt_cell
    import lbbrt_pkg::*;
#(
    parameter int unsigned RANK_W = 6
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire              i_alloc_me,
    input  wire              i_sel_me,
    input  wire [RANK_W-1:0] i_sel_rank,
    // chain of found flags from lower-indexed neighbor
    input  wire              i_found_prev,
    output logic             o_found_next,
    output logic             o_hit_first,
    output logic             o_valid,
    output logic             o_resident,
    output logic             o_dirty,
    output logic [31:0]      o_handle,
    output logic [31:0]      o_size,
    output logic [RANK_W-1:0] o_rank
);
    logic r_valid, r_res, r_dirty;
    logic [31:0] r_handle, r_size;
    logic [RANK_W-1:0] r_rank;
    logic w_hit;

    assign w_hit        = r_valid && (r_handle == i_cmd.handle);
    assign o_hit_first  = w_hit && !i_found_prev;
    assign o_found_next = w_hit || i_found_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_res   <= 1'b0;
            r_dirty <= 1'b0;
        end else begin
            if (i_cmd.alloc_en && i_alloc_me) begin
                r_valid  <= 1'b1;
                r_handle <= i_cmd.handle;
                r_size   <= i_cmd.new_size;
                r_dirty  <= 1'b0;
            end
            if (i_cmd.sel_en) begin
                if (i_sel_me) begin
                    if (i_cmd.rank_ins) begin
                        r_res  <= 1'b1;
                        r_rank <= '0;
                    end
                    if (i_cmd.rank_prom) r_rank <= '0;
                    if (i_cmd.rank_drop) begin
                        r_res   <= 1'b0;
                        r_dirty <= 1'b0;
                    end
                    if (i_cmd.set_dirty) r_dirty <= 1'b1;
                    if (i_cmd.kill) r_valid <= 1'b0;
                end else if (r_res) begin
                    if (i_cmd.rank_ins) r_rank <= r_rank + 1'b1;
                    if (i_cmd.rank_prom && r_rank < i_sel_rank) r_rank <= r_rank + 1'b1;
                    if (i_cmd.rank_drop && r_rank > i_sel_rank) r_rank <= r_rank - 1'b1;
                end
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_resident = r_res;
    assign o_dirty    = r_dirty;
    assign o_handle   = r_handle;
    assign o_size     = r_size;
    assign o_rank     = r_rank;
endmodule
`default_nettype wire
